// File: src/chipset_config_and_shadow_control_assert.svh
// assertion macros for the chipset register block
// expects clk and arst_n in the scope of each use
`ifndef CHIPSET_CONFIG_AND_SHADOW_CONTROL_ASSERT_SVH
`define CHIPSET_CONFIG_AND_SHADOW_CONTROL_ASSERT_SVH

// same-cycle implication
`define CCSC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("chipset register block check failed");

// next-cycle implication
`define CCSC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("chipset register block check failed");

`endif

// File: src/ccsc_pkg.sv
// shared types, codes and constant tables of the chipset register block
// no dependencies
package ccsc_pkg;

	localparam int EXT_REG_COUNT = 39;
	localparam int EXT_IDX_W     = $clog2(EXT_REG_COUNT);
	localparam int SEGMENTS      = 8;
	localparam int ACTION_W      = 3;
	localparam int ROUTE_W       = 5;

	localparam logic [ACTION_W-1:0] ACT_CFG_RD   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_CFG_WR   = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_PORT_RD  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_PORT_WR  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_CHIP_RST = 3'd4;

	localparam logic [7:0] EXT_FIRST       = 8'h50;
	localparam logic [7:0] EXT_LAST        = 8'h76;
	localparam logic [7:0] EXT_PROTECTED   = 8'h52;
	localparam logic [7:0] OFS_CACHE       = 8'h42;
	localparam logic [7:0] OFS_SHADOW_EN   = 8'h44;
	localparam logic [7:0] OFS_SHADOW_MODE = 8'h45;
	localparam logic [7:0] OFS_INDEX       = 8'h82;
	localparam logic [7:0] OFS_STORE_HIGH  = 8'h40;
	localparam logic [7:0] SHADOW_EN_QUIRK = 8'hf0;
	localparam logic [7:0] SHADOW_MD_QUIRK = 8'h01;
	localparam logic [7:0] READ_NONE       = 8'hff;
	localparam logic [ROUTE_W-1:0] ROUTE_OFF = 5'd16;

	typedef struct packed {
		logic       en;
		logic [7:0] addr;
		logic [7:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic                 en;
		logic [EXT_IDX_W-1:0] idx;
		logic [7:0]           data;
	} ext_wr_t;

	function automatic logic [7:0] size_code(input logic [7:0] mb);
		logic [7:0] r;
		if (mb <= 8'd1) r = 8'h00;
		else if (mb <= 8'd3) r = 8'h01;
		else if (mb == 8'd4) r = 8'h02;
		else if (mb == 8'd5) r = 8'h20;
		else if (mb <= 8'd7) r = 8'h09;
		else if (mb <= 8'd9) r = 8'h04;
		else if (mb <= 8'd11) r = 8'h05;
		else if (mb <= 8'd15) r = 8'h0b;
		else if (mb == 8'd16) r = 8'h13;
		else if (mb == 8'd17) r = 8'h21;
		else if (mb <= 8'd19) r = 8'h06;
		else if (mb <= 8'd23) r = 8'h0d;
		else if (mb <= 8'd31) r = 8'h0e;
		else if (mb <= 8'd35) r = 8'h1b;
		else if (mb <= 8'd39) r = 8'h0f;
		else if (mb <= 8'd47) r = 8'h17;
		else if (mb <= 8'd63) r = 8'h1e;
		else if (mb >= 8'd65 && mb <= 8'd67) r = 8'h22;
		else r = 8'h24;
		return r;
	endfunction

	localparam logic [7:0] EXT_SIZE_RESET = 8'h40 | size_code(8'd8);

	function automatic logic [7:0] cfg_reset_value(input logic [7:0] a);
		logic [7:0] r;
		case (a)
			8'h00: r = 8'h39;
			8'h01: r = 8'h10;
			8'h02: r = 8'h96;
			8'h03: r = 8'h04;
			8'h04: r = 8'h07;
			8'h06: r = 8'h80;
			8'h07: r = 8'h02;
			8'h08: r = 8'h02;
			8'h0b: r = 8'h06;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] ext_default(input logic [EXT_IDX_W-1:0] idx,
		input logic [7:0] code59);
		logic [7:0] r;
		case (idx)
			6'd9:  r = code59;
			6'd17: r = 8'h09;
			6'd18: r = 8'hff;
			6'd35: r = 8'hf0;
			6'd38: r = 8'h01;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// File: src/ccsc_req_if.sv
// request channel of the chipset register block
// depends on ccsc_pkg
interface ccsc_req_if;
	logic                          valid;
	logic                          ready;
	logic [ccsc_pkg::ACTION_W-1:0] action;
	logic [7:0]                    addr;
	logic [7:0]                    wdata;

	modport source(output valid, output action, output addr, output wdata, input ready);
	modport sink(input valid, input action, input addr, input wdata, output ready);
endinterface

// File: src/ccsc_rsp_if.sv
// result channel of the chipset register block
// depends on ccsc_pkg
interface ccsc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [7:0]                   read_data;
	logic [7:0]                   seg_read_internal;
	logic [7:0]                   seg_write_internal;
	logic                         bios_shadow_on;
	logic                         ext_cache_on;
	logic [ccsc_pkg::ROUTE_W-1:0] route_inta;
	logic [ccsc_pkg::ROUTE_W-1:0] route_intb;
	logic [ccsc_pkg::ROUTE_W-1:0] route_intc;
	logic [ccsc_pkg::ROUTE_W-1:0] route_intd;

	modport source(output valid, output read_data, output seg_read_internal,
		output seg_write_internal, output bios_shadow_on, output ext_cache_on,
		output route_inta, output route_intb, output route_intc, output route_intd,
		input ready);
	modport sink(input valid, input read_data, input seg_read_internal,
		input seg_write_internal, input bios_shadow_on, input ext_cache_on,
		input route_inta, input route_intb, input route_intc, input route_intd,
		output ready);
endinterface

// File: src/chipset_config_and_shadow_control.sv
// chipset register block top: request decode, read-modify-write of config and
// extended register memories, shadow map, cache flag and interrupt routing
// depends on ccsc_pkg, ccsc_req_if, ccsc_rsp_if, ccsc_cfg_mem, ccsc_ext_regs
//
//   channel  | kind         | moves
//   ---------+--------------+-------------------------------------------
//   req      | valid/ready  | action, addr, wdata
//   rsp      | valid/ready  | read_data, shadow map, cache flag, routes
//   cfg      | write enable | memory_mb
//
// the accept cycle issues the memory reads and loads the request stage; the update
// completes from that stage, and no new request is taken while it is occupied.
// reset clears all valid bits at once, no clearing pass.
// a result waits in the output register while the next request is accepted;
// a request waits in its stage until the output register is free.
module chipset_config_and_shadow_control (
	input  logic       clk,
	input  logic       arst_n,
	ccsc_req_if.sink   req,
	ccsc_rsp_if.source rsp,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);
	import ccsc_pkg::*;

	typedef struct packed {
		logic [7:0] rd;
		logic [7:0] wr;
		logic       bios;
	} shadow_map_t;

	function automatic shadow_map_t shadow_map(input logic [7:0] en, input logic [7:0] md);
		shadow_map_t m;
		m.rd   = 8'h00;
		m.wr   = 8'h00;
		m.bios = |en[7:4];
		case (md[1:0])
			2'd0: m.wr = en;
			2'd2: begin
				m.rd = en;
				m.wr = en;
			end
			2'd3: m.rd = en;
			default: ;
		endcase
		return m;
	endfunction

	function automatic logic ext_range(input logic [7:0] v);
		return (v >= EXT_FIRST) && (v <= EXT_LAST);
	endfunction

	logic [7:0]          memory_mb_q;
	logic                valid_s1;
	logic [ACTION_W-1:0] action_s1;
	logic [7:0]          addr_s1;
	logic [7:0]          wdata_s1;
	logic                out_valid_q;
	logic [7:0]          read_data_q;
	logic [7:0]          ext_index_q;
	logic [7:0]          shadow_en_q;
	logic [7:0]          shadow_md_q;
	shadow_map_t         map_q;
	logic                cache_q;
	logic [ROUTE_W-1:0]  route_q [4];

	logic                accept;
	logic                exec;
	logic                idx_in_range;
	logic [7:0]          idx_off;
	logic [EXT_IDX_W-1:0] ext_rd_idx;
	logic [7:0]          cfg_rdata;
	logic [7:0]          ext_rdata;
	cfg_wr_t             cfg_wr;
	ext_wr_t             ext_wr;
	logic                ext_clr;

	logic                cw_en;
	logic [7:0]          cw_addr;
	logic [7:0]          cw_val;
	logic [7:0]          rd_n;
	logic [7:0]          ext_index_n;
	logic [7:0]          shadow_en_n;
	logic [7:0]          shadow_md_n;
	shadow_map_t         map_n;
	logic                cache_n;
	logic [ROUTE_W-1:0]  route_n [4];

	assign req.ready    = !valid_s1;
	assign accept       = req.valid && req.ready;
	assign exec         = valid_s1 && (!out_valid_q || rsp.ready);
	assign idx_in_range = ext_range(ext_index_q);
	assign idx_off      = ext_index_q - EXT_FIRST;
	assign ext_rd_idx   = idx_in_range ? idx_off[EXT_IDX_W-1:0] : '0;

	ccsc_cfg_mem u_cfg_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (req.addr),
		.wr      (cfg_wr),
		.rd_data (cfg_rdata)
	);

	ccsc_ext_regs u_ext_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.memory_mb (memory_mb_q),
		.clear     (ext_clr),
		.rd_en     (accept),
		.rd_idx    (ext_rd_idx),
		.wr        (ext_wr),
		.rd_data   (ext_rdata)
	);

	always_comb begin
		cw_en       = 1'b0;
		cw_addr     = addr_s1;
		cw_val      = wdata_s1;
		rd_n        = 8'h00;
		ext_index_n = ext_index_q;
		shadow_en_n = shadow_en_q;
		shadow_md_n = shadow_md_q;
		map_n       = map_q;
		cache_n     = cache_q;
		route_n     = route_q;
		ext_clr     = 1'b0;
		ext_wr.en   = 1'b0;
		ext_wr.idx  = idx_off[EXT_IDX_W-1:0];
		ext_wr.data = wdata_s1;
		cfg_wr.en   = 1'b0;
		cfg_wr.addr = addr_s1;
		cfg_wr.data = wdata_s1;

		case (action_s1)
			ACT_CFG_RD: rd_n = cfg_rdata;
			ACT_CFG_WR: cw_en = 1'b1;
			ACT_PORT_RD: begin
				if (!addr_s1[0]) begin
					rd_n = ext_index_q;
				end else if (idx_in_range) begin
					rd_n        = ext_rdata;
					ext_index_n = 8'h00;
				end else begin
					rd_n = READ_NONE;
				end
			end
			ACT_PORT_WR: begin
				if (!addr_s1[0]) begin
					if (ext_range(wdata_s1)) begin
						ext_index_n = wdata_s1;
					end
				end else if (idx_in_range) begin
					ext_wr.en   = (ext_index_q != EXT_PROTECTED);
					ext_index_n = 8'h00;
				end
			end
			ACT_CHIP_RST: begin
				cw_en   = 1'b1;
				cw_addr = OFS_SHADOW_EN;
				cw_val  = shadow_en_q & 8'h0f;
				ext_clr = 1'b1;
			end
			default: ;
		endcase

		if (cw_en) begin
			case (cw_addr) inside
				OFS_CACHE: cache_n = cw_val[0];
				OFS_SHADOW_EN: begin
					shadow_en_n = cw_val;
					if ((shadow_en_q & cw_val) != SHADOW_EN_QUIRK) begin
						map_n = shadow_map(cw_val, shadow_md_q);
					end
				end
				OFS_SHADOW_MODE: begin
					shadow_md_n = cw_val;
					if ((shadow_md_q & cw_val) != SHADOW_MD_QUIRK) begin
						map_n = shadow_map(shadow_en_q, cw_val);
					end
				end
				OFS_INDEX: begin
					if (ext_range(cw_val)) begin
						ext_index_n = cw_val;
					end
				end
				[8'hc0:8'hc3]: begin
					route_n[cw_addr[1:0]] = cw_val[7] ? {1'b0, cw_val[3:0]} : ROUTE_OFF;
				end
				default: ;
			endcase
			cfg_wr.en   = exec && (((cw_addr >= 8'h04) && (cw_addr < 8'h08)) ||
				(cw_addr >= OFS_STORE_HIGH));
			cfg_wr.addr = cw_addr;
			cfg_wr.data = cw_val;
		end

		if (ext_clr) begin
			ext_index_n = 8'h00;
		end

		ext_clr   = ext_clr && exec;
		ext_wr.en = ext_wr.en && exec;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= req.action;
			addr_s1   <= req.addr;
			wdata_s1  <= req.wdata;
		end
		if (exec) begin
			read_data_q <= rd_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			memory_mb_q <= 8'd8;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			ext_index_q <= 8'h00;
			shadow_en_q <= 8'h00;
			shadow_md_q <= 8'h00;
			map_q       <= '0;
			cache_q     <= 1'b0;
			route_q     <= '{default: ROUTE_OFF};
		end else begin
			if (cfg_we) begin
				memory_mb_q <= cfg_wdata;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (exec) begin
				valid_s1 <= 1'b0;
			end
			if (exec) begin
				out_valid_q <= 1'b1;
				ext_index_q <= ext_index_n;
				shadow_en_q <= shadow_en_n;
				shadow_md_q <= shadow_md_n;
				map_q       <= map_n;
				cache_q     <= cache_n;
				route_q     <= route_n;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.read_data          = read_data_q;
	assign rsp.seg_read_internal  = map_q.rd;
	assign rsp.seg_write_internal = map_q.wr;
	assign rsp.bios_shadow_on     = map_q.bios;
	assign rsp.ext_cache_on       = cache_q;
	assign rsp.route_inta         = route_q[0];
	assign rsp.route_intb         = route_q[1];
	assign rsp.route_intc         = route_q[2];
	assign rsp.route_intd         = route_q[3];

`include "chipset_config_and_shadow_control_assert.svh"

	`CCSC_ASSERT_NOW(a_index_legal, 1'b1, (ext_index_q == 8'h00) || ext_range(ext_index_q))
	`CCSC_ASSERT_NEXT(a_data_read_clears_index, exec && (action_s1 == ACT_PORT_RD) && addr_s1[0] && idx_in_range, ext_index_q == 8'h00)
	`CCSC_ASSERT_NEXT(a_exec_gives_result, exec, out_valid_q && !valid_s1)
	`CCSC_ASSERT_NOW(a_protected_kept, ext_wr.en, ext_index_q != EXT_PROTECTED)
endmodule

// File: src/ccsc_cfg_mem.sv
// 256-byte config space memory with a registered read
// per-byte valid bits give the power-on value until first write; depends on ccsc_pkg
module ccsc_cfg_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [7:0]        rd_addr,
	input  ccsc_pkg::cfg_wr_t wr,
	output logic [7:0]        rd_data
);
	import ccsc_pkg::*;

	logic [7:0]   mem [256];
	logic [255:0] vld_q;
	logic [7:0]   mem_rd_q;
	logic [7:0]   rd_addr_q;
	logic         rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			mem_rd_q  <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? mem_rd_q : cfg_reset_value(rd_addr_q);
endmodule

// File: src/ccsc_ext_regs.sv
// extended register file behind the index/data port pair, with a registered read
// clear restores defaults through valid bits and latches the size code; depends on ccsc_pkg
module ccsc_ext_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [7:0]                     memory_mb,
	input  logic                           clear,
	input  logic                           rd_en,
	input  logic [ccsc_pkg::EXT_IDX_W-1:0] rd_idx,
	input  ccsc_pkg::ext_wr_t              wr,
	output logic [7:0]                     rd_data
);
	import ccsc_pkg::*;

	logic [7:0]               mem [EXT_REG_COUNT];
	logic [EXT_REG_COUNT-1:0] vld_q;
	logic [7:0]               mem_rd_q;
	logic [EXT_IDX_W-1:0]     rd_idx_q;
	logic                     rd_vld_q;
	logic [7:0]               code59_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_idx];
			rd_idx_q <= rd_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			code59_q <= EXT_SIZE_RESET;
		end else begin
			if (clear) begin
				vld_q    <= '0;
				code59_q <= 8'h40 | size_code(memory_mb);
			end else if (wr.en) begin
				vld_q[wr.idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_idx];
			end
		end
	end

	assign rd_data = rd_vld_q ? mem_rd_q : ext_default(rd_idx_q, code59_q);
endmodule

// File: sim/chipset_config_and_shadow_control_tb.sv
// testbench for the chipset register block: drives request streams, predicts every result
// and checks every field of it; uses ccsc_pkg, ccsc_req_if, ccsc_rsp_if and the block top
`timescale 1ns / 100ps

module chipset_config_and_shadow_control_tb;
	import ccsc_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_LAST = 3'd7;
	localparam logic [7:0] OFS_STORE_LO     = 8'h04;
	localparam logic [7:0] OFS_STORE_LO_END = 8'h07;
	localparam logic [7:0] OFS_ROUTE_LO     = 8'hc0;
	localparam logic [7:0] OFS_ROUTE_HI     = 8'hc3;
	localparam logic [7:0] SHADOW_LOW_MASK  = 8'h0f;
	localparam logic [7:0] XR_SIZE          = 8'h59;
	localparam logic [7:0] XR_CTRL_A        = 8'h61;
	localparam logic [7:0] XR_CTRL_B        = 8'h62;
	localparam logic [7:0] XR_CTRL_C        = 8'h73;
	localparam logic [7:0] XR_CTRL_D        = 8'h76;
	localparam logic [1:0] MODE_WR_ONLY     = 2'd0;
	localparam logic [1:0] MODE_RW          = 2'd2;
	localparam logic [1:0] MODE_RD_ONLY     = 2'd3;
	localparam int RANDOM_PER_PHASE = 107;
	localparam int STALL_AFTER      = 500;
	localparam int STALL_CYCLES     = 200;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [7:0]          addr;
		logic [7:0]          wdata;
	} access_t;

	typedef struct packed {
		logic [7:0]         read_data;
		logic [7:0]         seg_rd;
		logic [7:0]         seg_wr;
		logic               bios;
		logic               cache;
		logic [ROUTE_W-1:0] inta;
		logic [ROUTE_W-1:0] intb;
		logic [ROUTE_W-1:0] intc;
		logic [ROUTE_W-1:0] intd;
	} reg_view_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'h00;

	logic drv_valid = 1'b0;
	logic [ACTION_W-1:0] drv_action = '0;
	logic [7:0] drv_addr = 8'h00;
	logic [7:0] drv_wdata = 8'h00;
	logic drv_ready = 1'b0;
	logic calm = 1'b0;

	ccsc_req_if req_ch();
	ccsc_rsp_if rsp_ch();

	assign req_ch.valid = drv_valid;
	assign req_ch.action = drv_action;
	assign req_ch.addr = drv_addr;
	assign req_ch.wdata = drv_wdata;
	assign rsp_ch.ready = drv_ready;

	chipset_config_and_shadow_control i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// shadow of the block state
	logic [7:0] mem_size_mb;
	logic [7:0] cspace [256];
	logic [7:0] xidx;
	logic [7:0] xreg [EXT_FIRST:EXT_LAST];
	logic [7:0] map_rd;
	logic [7:0] map_wr;
	logic map_bios;
	logic cache_en;
	logic [ROUTE_W-1:0] irq_route [4];

	access_t pend_q[$];
	reg_view_t view_q[$];
	int n_err = 0;

	function automatic logic [7:0] mem_size_code(logic [7:0] mb);
		if (mb <= 8'd1) return 8'h00;
		if (mb <= 8'd3) return 8'h01;
		if (mb == 8'd4) return 8'h02;
		if (mb == 8'd5) return 8'h20;
		if (mb <= 8'd7) return 8'h09;
		if (mb <= 8'd9) return 8'h04;
		if (mb <= 8'd11) return 8'h05;
		if (mb <= 8'd15) return 8'h0b;
		if (mb == 8'd16) return 8'h13;
		if (mb == 8'd17) return 8'h21;
		if (mb <= 8'd19) return 8'h06;
		if (mb <= 8'd23) return 8'h0d;
		if (mb <= 8'd31) return 8'h0e;
		if (mb <= 8'd35) return 8'h1b;
		if (mb <= 8'd39) return 8'h0f;
		if (mb <= 8'd47) return 8'h17;
		if (mb <= 8'd63) return 8'h1e;
		if (mb >= 8'd65 && mb <= 8'd67) return 8'h22;
		return 8'h24;
	endfunction

	function automatic logic idx_ok(logic [7:0] i);
		return i >= EXT_FIRST && i <= EXT_LAST;
	endfunction

	function automatic void index_write(logic [7:0] v);
		if (idx_ok(v))
			xidx = v;
	endfunction

	function automatic void reload_ext();
		for (int i = EXT_FIRST; i <= EXT_LAST; i++)
			xreg[i] = 8'h00;
		xidx = 8'h00;
		xreg[XR_SIZE] = 8'h40 | mem_size_code(mem_size_mb);
		xreg[XR_CTRL_A] = 8'h09;
		xreg[XR_CTRL_B] = 8'hff;
		xreg[XR_CTRL_C] = 8'hf0;
		xreg[XR_CTRL_D] = 8'h01;
	endfunction

	function automatic void refresh_map();
		logic [1:0] mode;
		logic [7:0] en;
		mode = cspace[OFS_SHADOW_MODE][1:0];
		en = cspace[OFS_SHADOW_EN];
		map_rd = (mode == MODE_RW || mode == MODE_RD_ONLY) ? en : 8'h00;
		map_wr = (mode == MODE_RW || mode == MODE_WR_ONLY) ? en : 8'h00;
		map_bios = |en[7:4];
	endfunction

	function automatic void cfg_store(logic [7:0] a, logic [7:0] v);
		if (a == OFS_CACHE) begin
			cache_en = v[0];
		end else if (a == OFS_SHADOW_EN) begin
			if ((cspace[a] & v) != SHADOW_EN_QUIRK) begin
				cspace[a] = v;
				refresh_map();
			end
		end else if (a == OFS_SHADOW_MODE) begin
			if ((cspace[a] & v) != SHADOW_MD_QUIRK) begin
				cspace[a] = v;
				refresh_map();
			end
		end else if (a == OFS_INDEX) begin
			index_write(v);
		end else if (a >= OFS_ROUTE_LO && a <= OFS_ROUTE_HI) begin
			irq_route[a[1:0]] = v[7] ? {1'b0, v[3:0]} : ROUTE_OFF;
		end
		if ((a >= OFS_STORE_LO && a <= OFS_STORE_LO_END) || a >= OFS_STORE_HIGH)
			cspace[a] = v;
	endfunction

	function automatic reg_view_t predict_view(access_t r);
		reg_view_t o;
		o.read_data = 8'h00;
		case (r.action)
			ACT_CFG_RD: o.read_data = cspace[r.addr];
			ACT_CFG_WR: cfg_store(r.addr, r.wdata);
			ACT_PORT_RD: begin
				if (!r.addr[0]) begin
					o.read_data = xidx;
				end else if (idx_ok(xidx)) begin
					o.read_data = xreg[xidx];
					xidx = 8'h00;
				end else begin
					o.read_data = READ_NONE;
				end
			end
			ACT_PORT_WR: begin
				if (!r.addr[0]) begin
					index_write(r.wdata);
				end else if (idx_ok(xidx)) begin
					if (xidx != EXT_PROTECTED)
						xreg[xidx] = r.wdata;
					xidx = 8'h00;
				end
			end
			ACT_CHIP_RST: begin
				cfg_store(OFS_SHADOW_EN, cspace[OFS_SHADOW_EN] & SHADOW_LOW_MASK);
				reload_ext();
			end
			default: ;
		endcase
		o.seg_rd = map_rd;
		o.seg_wr = map_wr;
		o.bios = map_bios;
		o.cache = cache_en;
		o.inta = irq_route[0];
		o.intb = irq_route[1];
		o.intc = irq_route[2];
		o.intd = irq_route[3];
		return o;
	endfunction

	function automatic void push_req(logic [ACTION_W-1:0] act, logic [7:0] a, logic [7:0] d);
		access_t r;
		r.action = act;
		r.addr = a;
		r.wdata = d;
		pend_q.push_back(r);
	endfunction

	function automatic logic [7:0] rand_port(logic data_side);
		logic [7:0] a;
		a = 8'($urandom);
		a[0] = data_side;
		return a;
	endfunction

	function automatic logic [7:0] rand_index();
		if ($urandom_range(9) == 0)
			return 8'($urandom);
		return 8'($urandom_range(EXT_LAST, EXT_FIRST));
	endfunction

	task automatic add_random();
		int unsigned pick;
		logic [7:0] d;
		pick = $urandom_range(99);
		if (pick < 30) begin
			// index select followed by a data access
			if ($urandom_range(1))
				push_req(ACT_PORT_WR, rand_port(1'b0), rand_index());
			else
				push_req(ACT_CFG_WR, OFS_INDEX, rand_index());
			if ($urandom_range(3) == 0)
				push_req(ACT_PORT_RD, rand_port(1'b0), 8'($urandom));
			if ($urandom_range(1))
				push_req(ACT_PORT_RD, rand_port(1'b1), 8'($urandom));
			else
				push_req(ACT_PORT_WR, rand_port(1'b1), 8'($urandom));
		end else if (pick < 40) begin
			d = $urandom_range(1) ? {4'hf, 4'($urandom)} : 8'($urandom);
			push_req(ACT_CFG_WR, OFS_SHADOW_EN, d);
			if ($urandom_range(1))
				push_req(ACT_CFG_RD, OFS_SHADOW_EN, 8'($urandom));
		end else if (pick < 50) begin
			d = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
			push_req(ACT_CFG_WR, OFS_SHADOW_MODE, d);
		end else if (pick < 58) begin
			push_req(ACT_CFG_WR, 8'($urandom_range(OFS_ROUTE_HI, OFS_ROUTE_LO)),
				8'($urandom));
		end else if (pick < 63) begin
			push_req(ACT_CFG_WR, OFS_CACHE, 8'($urandom));
		end else if (pick < 78) begin
			d = ($urandom_range(2) == 0) ? 8'($urandom_range(15)) : 8'($urandom);
			push_req(ACT_CFG_RD, d, 8'($urandom));
		end else if (pick < 88) begin
			d = ($urandom_range(2) == 0) ? 8'($urandom_range(15)) : 8'($urandom);
			push_req(ACT_CFG_WR, d, 8'($urandom));
			push_req(ACT_CFG_RD, d, 8'($urandom));
		end else if (pick < 93) begin
			push_req($urandom_range(1) ? ACT_PORT_RD : ACT_PORT_WR, 8'($urandom),
				8'($urandom));
		end else if (pick < 97) begin
			push_req(ACT_CHIP_RST, 8'($urandom), 8'($urandom));
		end else begin
			push_req(3'($urandom_range(ACT_LAST, ACT_CHIP_RST + 1)), 8'($urandom),
				8'($urandom));
		end
	endtask

	task automatic drain();
		wait (pend_q.size() == 0 && !drv_valid && view_q.size() == 0);
		repeat (6) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk) begin
		access_t nxt;
		if (arst_n && (!drv_valid || req_ch.ready)) begin
			if (pend_q.size() > 0 && (calm || $urandom_range(99) >= 28)) begin
				nxt = pend_q.pop_front();
				drv_valid <= 1'b1;
				drv_action <= nxt.action;
				drv_addr <= nxt.addr;
				drv_wdata <= nxt.wdata;
			end else begin
				drv_valid <= 1'b0;
			end
		end
	end

	// result side ready, with one long hold-off
	int req_seen = 0;
	int stall_left = 0;
	logic stall_done = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready)
				req_seen <= req_seen + 1;
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				drv_ready <= 1'b0;
			end else if (!stall_done && req_seen >= STALL_AFTER) begin
				stall_left <= STALL_CYCLES;
				stall_done <= 1'b1;
				drv_ready <= 1'b0;
			end else begin
				drv_ready <= calm || ($urandom_range(99) >= 28);
			end
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		reg_view_t got;
		reg_view_t want;
		access_t acc;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.read_data = rsp_ch.read_data;
				got.seg_rd = rsp_ch.seg_read_internal;
				got.seg_wr = rsp_ch.seg_write_internal;
				got.bios = rsp_ch.bios_shadow_on;
				got.cache = rsp_ch.ext_cache_on;
				got.inta = rsp_ch.route_inta;
				got.intb = rsp_ch.route_intb;
				got.intc = rsp_ch.route_intc;
				got.intd = rsp_ch.route_intd;
				if (view_q.size() == 0) begin
					n_err++;
					if (n_err <= 10)
						$display("%0t: result with no request pending", $realtime);
				end else begin
					want = view_q.pop_front();
					if (got !== want) begin
						n_err++;
						if (n_err <= 10)
							$display("%0t: mismatch exp rd=%h ri=%h wi=%h bs=%b ec=%b rt=%0d/%0d/%0d/%0d act rd=%h ri=%h wi=%h bs=%b ec=%b rt=%0d/%0d/%0d/%0d",
								$realtime, want.read_data, want.seg_rd, want.seg_wr,
								want.bios, want.cache, want.inta, want.intb, want.intc,
								want.intd, got.read_data, got.seg_rd, got.seg_wr,
								got.bios, got.cache, got.inta, got.intb, got.intc,
								got.intd);
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				acc.action = req_ch.action;
				acc.addr = req_ch.addr;
				acc.wdata = req_ch.wdata;
				view_q.push_back(predict_view(acc));
			end
		end
	end

	initial begin
		logic [7:0] mb_list [7];
		mb_list = '{8'd0, 8'd255, 8'd64, 8'd65, 8'd16, 8'd5, 8'($urandom)};

		mem_size_mb = 8'd8;
		for (int i = 0; i < 256; i++)
			cspace[i] = 8'h00;
		cspace[8'h00] = 8'h39;
		cspace[8'h01] = 8'h10;
		cspace[8'h02] = 8'h96;
		cspace[8'h03] = 8'h04;
		cspace[8'h04] = 8'h07;
		cspace[8'h06] = 8'h80;
		cspace[8'h07] = 8'h02;
		cspace[8'h08] = 8'h02;
		cspace[8'h0b] = 8'h06;
		map_rd = 8'h00;
		map_wr = 8'h00;
		map_bios = 1'b0;
		cache_en = 1'b0;
		for (int i = 0; i < 4; i++)
			irq_route[i] = ROUTE_OFF;
		reload_ext();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed opening
		push_req(ACT_CFG_RD, 8'h00, 8'h00);
		push_req(ACT_CFG_RD, 8'h0b, 8'hff);
		push_req(ACT_CFG_WR, 8'h02, 8'haa);
		push_req(ACT_CFG_RD, 8'h02, 8'h00);
		push_req(ACT_CFG_WR, OFS_STORE_LO_END, 8'h55);
		push_req(ACT_CFG_RD, OFS_STORE_LO_END, 8'h00);
		push_req(ACT_CFG_RD, 8'hff, 8'h00);
		push_req(ACT_CFG_WR, OFS_CACHE, 8'hff);
		push_req(ACT_CFG_WR, OFS_SHADOW_MODE, 8'h02);
		push_req(ACT_CFG_WR, OFS_SHADOW_EN, 8'hff);
		push_req(ACT_CFG_WR, OFS_SHADOW_EN, 8'hf0);
		push_req(ACT_CFG_WR, OFS_SHADOW_MODE, 8'h03);
		push_req(ACT_CFG_WR, OFS_SHADOW_MODE, 8'h01);
		push_req(ACT_CFG_WR, OFS_ROUTE_LO, 8'h8f);
		push_req(ACT_CFG_WR, OFS_ROUTE_HI, 8'h00);
		push_req(ACT_PORT_WR, 8'h00, 8'h4f);
		push_req(ACT_PORT_RD, 8'hff, 8'h00);
		push_req(ACT_PORT_WR, 8'hfe, EXT_PROTECTED);
		push_req(ACT_PORT_WR, 8'h01, 8'h33);
		push_req(ACT_PORT_RD, 8'h00, 8'h00);
		push_req(ACT_CFG_WR, OFS_INDEX, XR_SIZE);
		push_req(ACT_PORT_RD, 8'h01, 8'h00);
		push_req(ACT_CHIP_RST, 8'h00, 8'h00);
		for (int a = ACT_CHIP_RST + 1; a <= ACT_LAST; a++)
			push_req(3'(a), 8'hff, 8'hff);

		for (int ph = 0; ph <= 7; ph++) begin
			if (ph > 0) begin
				drain();
				cfg_we <= 1'b1;
				cfg_wdata <= mb_list[ph-1];
				@(posedge clk);
				mem_size_mb = mb_list[ph-1];
				cfg_we <= 1'b0;
				calm <= (ph == 2);
				@(posedge clk);
				push_req(ACT_CHIP_RST, 8'($urandom), 8'($urandom));
				push_req(ACT_PORT_WR, rand_port(1'b0), XR_SIZE);
				push_req(ACT_PORT_RD, rand_port(1'b1), 8'($urandom));
			end
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				add_random();
		end

		drain();
		repeat (20) @(posedge clk);
		if (n_err == 0)
			$display("chipset_config_and_shadow_control_tb: clean");
		else
			$display("chipset_config_and_shadow_control_tb: errors");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("chipset_config_and_shadow_control_tb: errors");
		$finish;
	end

endmodule
